[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define SEPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold
`define SEPA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/sepa_pkg.sv]
package sepa_pkg;

  localparam int unsigned MaxExtentsDef = 16;
  localparam int unsigned ResultCap     = 16;
  localparam int unsigned NW            = $clog2(ResultCap + 1);
  localparam int unsigned KW            = $clog2(ResultCap);

  localparam logic [1:0] ReqAlloc = 2'd0;
  localparam logic [1:0] ReqFree  = 2'd1;
  localparam logic [1:0] ReqInit  = 2'd2;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusOom  = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  localparam logic CfgTotal    = 1'b0;
  localparam logic CfgReserved = 1'b1;

  localparam logic [15:0] ResetTotal    = 16'd4096;
  localparam logic [15:0] ResetReserved = 16'd0;

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic step_ok;
    logic last;
  } sts_t;

endpackage

[rtl/sorted_extent_page_allocator.sv]
// Free-extent page allocator that takes pages from the lowest-addressed
// extents first. Each request gives one result per granted piece (alloc,
// at most 16 pieces, or a single result if none is granted) or a single
// result (free, reinit, no-op). An alloc runs a single table-walk step
// that takes from the lowest extent each cycle, then the results are emitted.
// Only one request is in flight; the input stalls until its last result is
// taken.
module sorted_extent_page_allocator #(
  parameter int unsigned MaxExtents = sepa_pkg::MaxExtentsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] page_count_i,
  input  logic [15:0] page_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] extent_start_o,
  output logic [15:0] extent_length_o,
  output logic [1:0]  status_o,
  output logic [15:0] pages_in_use_o,
  output logic        last_o
);

  sepa_pkg::cmd_t cmd;
  sepa_pkg::sts_t sts;

  sepa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sepa_dp #(
    .MaxExtents (MaxExtents)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .page_count_i    (page_count_i),
    .page_address_i  (page_address_i),
    .extent_start_o  (extent_start_o),
    .extent_length_o (extent_length_o),
    .status_o        (status_o),
    .pages_in_use_o  (pages_in_use_o),
    .last_o          (last_o)
  );

endmodule

[rtl/sepa_ctrl.sv]
`include "assert_macros.svh"

module sepa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  sepa_pkg::sts_t    sts_i,
  output sepa_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StAlloc = 2'd1;
  localparam logic [1:0] StEmit  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StEmit);
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          state_d = (req_type_i == sepa_pkg::ReqAlloc) ? StAlloc : StEmit;
        end
      end
      StAlloc: begin
        if (sts_i.step_ok) begin
          cmd_o.step = 1'b1;
        end else begin
          cmd_o.finish = 1'b1;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!out_stall_i) begin
          if (sts_i.last) begin
            state_d = StIdle;
          end else begin
            cmd_o.emit_next = 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `SEPA_ASSERT(a_accept_idle, accept |-> state_q == StIdle, "request accepted while busy")
  `SEPA_ASSERT(a_alloc_done, (state_q == StAlloc && !sts_i.step_ok) |=> state_q == StEmit, "alloc did not finish")
  `SEPA_ASSERT(a_last_idle, (out_valid_o && !out_stall_i && sts_i.last) |=> state_q == StIdle, "no return to idle after last")
  `SEPA_NEVER(a_one_cmd, !$onehot0(cmd_o), "several commands at once")

endmodule

[rtl/sepa_dp.sv]
module sepa_dp #(
  parameter int unsigned MaxExtents = sepa_pkg::MaxExtentsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [15:0]    cfg_data_i,
  input  sepa_pkg::cmd_t cmd_i,
  output sepa_pkg::sts_t sts_o,
  input  logic [1:0]     req_type_i,
  input  logic [15:0]    page_count_i,
  input  logic [15:0]    page_address_i,
  output logic [15:0]    extent_start_o,
  output logic [15:0]    extent_length_o,
  output logic [1:0]     status_o,
  output logic [15:0]    pages_in_use_o,
  output logic           last_o
);

  localparam int unsigned CntW = $clog2(MaxExtents + 1);
  localparam int unsigned NW   = sepa_pkg::NW;
  localparam int unsigned KW   = sepa_pkg::KW;

  logic [15:0] total_q, reserved_q;
  logic [15:0] st_q [MaxExtents];
  logic [15:0] ln_q [MaxExtents];
  logic [15:0] st_d [MaxExtents];
  logic [15:0] ln_d [MaxExtents];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0] used_q, used_d;
  logic [15:0] rem_q, rem_d;
  logic [NW-1:0] n_q, n_d;
  logic [KW-1:0] k_q, k_d;
  logic [1:0]  status_q, status_d;
  logic [15:0] pst_q [sepa_pkg::ResultCap];
  logic [15:0] pln_q [sepa_pkg::ResultCap];

  logic [15:0] take, adv_s, adv_l;
  logic        whole;
  logic [MaxExtents-1:0] lt_adv, lt_ins;

  assign take  = (ln_q[0] < rem_q) ? ln_q[0] : rem_q;
  assign whole = (take == ln_q[0]);
  assign adv_s = st_q[0] + take;
  assign adv_l = ln_q[0] - take;

  always_comb begin
    for (int j = 0; j < MaxExtents; j++) begin
      lt_adv[j] = (j >= 1) && (CntW'(j) < cnt_q) && (st_q[j] < adv_s);
      lt_ins[j] = (CntW'(j) < cnt_q) && (st_q[j] < page_address_i);
    end
  end

  assign sts_o.step_ok = (rem_q != '0) && (cnt_q != '0) && (n_q < NW'(sepa_pkg::ResultCap));
  assign sts_o.last    = (n_q == '0) || ({1'b0, k_q} == n_q - NW'(1));

  always_comb begin
    st_d     = st_q;
    ln_d     = ln_q;
    cnt_d    = cnt_q;
    used_d   = used_q;
    rem_d    = rem_q;
    n_d      = n_q;
    k_d      = k_q;
    status_d = status_q;
    if (cmd_i.accept) begin
      n_d      = '0;
      k_d      = '0;
      rem_d    = page_count_i;
      status_d = sepa_pkg::StatusOk;
      case (req_type_i)
        sepa_pkg::ReqFree: begin
          if (page_count_i != '0) begin
            if (cnt_q >= CntW'(MaxExtents)) begin
              status_d = sepa_pkg::StatusFull;
            end else begin
              for (int i = 0; i < MaxExtents; i++) begin
                if (lt_ins[i]) begin
                  st_d[i] = st_q[i];
                  ln_d[i] = ln_q[i];
                end else if (i == 0 || lt_ins[(i == 0) ? 0 : i - 1]) begin
                  st_d[i] = page_address_i;
                  ln_d[i] = page_count_i;
                end else begin
                  st_d[i] = st_q[(i == 0) ? 0 : i - 1];
                  ln_d[i] = ln_q[(i == 0) ? 0 : i - 1];
                end
              end
              cnt_d  = cnt_q + CntW'(1);
              used_d = used_q - page_count_i;
            end
          end
        end
        sepa_pkg::ReqInit: begin
          st_d[0] = reserved_q;
          ln_d[0] = total_q - reserved_q;
          cnt_d   = (reserved_q < total_q) ? CntW'(1) : '0;
          used_d  = reserved_q;
        end
        default: ;
      endcase
    end else if (cmd_i.step) begin
      if (whole) begin
        for (int i = 0; i < MaxExtents - 1; i++) begin
          st_d[i] = st_q[i + 1];
          ln_d[i] = ln_q[i + 1];
        end
        cnt_d = cnt_q - CntW'(1);
      end else begin
        for (int i = 0; i < MaxExtents; i++) begin
          if (i + 1 < MaxExtents && lt_adv[(i + 1 < MaxExtents) ? i + 1 : i]) begin
            st_d[i] = st_q[(i + 1 < MaxExtents) ? i + 1 : i];
            ln_d[i] = ln_q[(i + 1 < MaxExtents) ? i + 1 : i];
          end else if (i == 0 || lt_adv[i]) begin
            st_d[i] = adv_s;
            ln_d[i] = adv_l;
          end
        end
      end
      n_d    = n_q + NW'(1);
      rem_d  = rem_q - take;
      used_d = used_q + take;
    end else if (cmd_i.finish) begin
      status_d = (rem_q != '0) ? sepa_pkg::StatusOom : sepa_pkg::StatusOk;
    end else if (cmd_i.emit_next) begin
      k_d = k_q + KW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= sepa_pkg::ResetTotal;
      reserved_q <= sepa_pkg::ResetReserved;
      cnt_q      <= (sepa_pkg::ResetReserved < sepa_pkg::ResetTotal) ? CntW'(1) : '0;
      used_q     <= sepa_pkg::ResetReserved;
      rem_q      <= '0;
      n_q        <= '0;
      k_q        <= '0;
      status_q   <= sepa_pkg::StatusOk;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sepa_pkg::CfgTotal:    total_q    <= cfg_data_i;
          sepa_pkg::CfgReserved: reserved_q <= cfg_data_i;
          default: ;
        endcase
      end
      cnt_q    <= cnt_d;
      used_q   <= used_d;
      rem_q    <= rem_d;
      n_q      <= n_d;
      k_q      <= k_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxExtents; i++) begin
        st_q[i] <= (i == 0) ? sepa_pkg::ResetReserved : '0;
        ln_q[i] <= (i == 0) ? sepa_pkg::ResetTotal - sepa_pkg::ResetReserved : '0;
      end
    end else begin
      st_q <= st_d;
      ln_q <= ln_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      pst_q[n_q[KW-1:0]] <= st_q[0];
      pln_q[n_q[KW-1:0]] <= take;
    end
  end

  assign extent_start_o  = (n_q == '0) ? '0 : pst_q[k_q];
  assign extent_length_o = (n_q == '0) ? '0 : pln_q[k_q];
  assign status_o        = status_q;
  assign pages_in_use_o  = used_q;
  assign last_o          = sts_o.last;

endmodule

[sim/tb_sorted_extent_page_allocator.sv]
`timescale 1ns / 1ps

module tb_sorted_extent_page_allocator;

  localparam logic [1:0] ReqNop = 2'd3;
  localparam int unsigned TableDepth = 16;
  localparam int unsigned PieceCap = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] count;
    logic [15:0] addr;
  } request_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] length;
    logic [1:0]  status;
    logic [15:0] in_use;
    logic        last;
  } grant_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [15:0] page_count_i;
  logic [15:0] page_address_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] extent_start_o;
  logic [15:0] extent_length_o;
  logic [1:0]  status_o;
  logic [15:0] pages_in_use_o;
  logic        last_o;

  sorted_extent_page_allocator i_dut (.*);

  request_t    pending_q[$];
  grant_t      grants_q[$];

  logic [15:0] free_start[TableDepth];
  logic [15:0] free_len[TableDepth];
  int unsigned free_cnt;
  logic [15:0] busy_pages;
  logic [15:0] cfg_total;
  logic [15:0] cfg_reserved;

  bit          quiet;
  int          hold_req;
  int          hold_seen;
  int          hold_cnt;
  int          errors;
  int          n_requests;
  int          n_results;
  int          n_configs;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void rebuild_free_table();
    free_cnt = 0;
    if (cfg_reserved < cfg_total) begin
      free_start[0] = cfg_reserved;
      free_len[0]   = cfg_total - cfg_reserved;
      free_cnt      = 1;
    end
    busy_pages = cfg_reserved;
  endfunction

  function automatic void push_grant(logic [15:0] s, logic [15:0] l, logic [1:0] st,
                                     logic lst);
    grant_t g;
    g.start  = s;
    g.length = l;
    g.status = st;
    g.in_use = busy_pages;
    g.last   = lst;
    grants_q.push_back(g);
  endfunction

  function automatic void grant_pages(logic [15:0] want);
    logic [15:0] ps[PieceCap];
    logic [15:0] pl[PieceCap];
    logic [15:0] s;
    logic [15:0] l;
    logic [15:0] take;
    int unsigned remaining;
    int unsigned granted;
    int unsigned n;
    int unsigned i;
    logic [1:0] st;
    remaining = want;
    granted = 0;
    n = 0;
    while (remaining > 0 && free_cnt > 0 && n < PieceCap) begin
      s = free_start[0];
      l = free_len[0];
      take = (l < remaining) ? l : remaining[15:0];
      ps[n] = s;
      pl[n] = take;
      n++;
      remaining -= take;
      granted += take;
      if (take == l) begin
        for (i = 0; i + 1 < free_cnt; i++) begin
          free_start[i] = free_start[i+1];
          free_len[i]   = free_len[i+1];
        end
        free_cnt--;
      end else begin
        s = s + take;
        l = l - take;
        i = 0;
        while (i + 1 < free_cnt && free_start[i+1] < s) begin
          free_start[i] = free_start[i+1];
          free_len[i]   = free_len[i+1];
          i++;
        end
        free_start[i] = s;
        free_len[i]   = l;
      end
    end
    busy_pages = busy_pages + granted[15:0];
    st = (remaining > 0) ? sepa_pkg::StatusOom : sepa_pkg::StatusOk;
    if (n == 0) begin
      push_grant(16'd0, 16'd0, st, 1'b1);
    end else begin
      for (i = 0; i < n; i++) push_grant(ps[i], pl[i], st, i == n - 1);
    end
  endfunction

  function automatic void return_extent(logic [15:0] count, logic [15:0] addr);
    int unsigned pos;
    int unsigned i;
    if (count == 0) begin
      push_grant(16'd0, 16'd0, sepa_pkg::StatusOk, 1'b1);
    end else if (free_cnt >= TableDepth) begin
      push_grant(16'd0, 16'd0, sepa_pkg::StatusFull, 1'b1);
    end else begin
      pos = 0;
      while (pos < free_cnt && free_start[pos] < addr) pos++;
      for (i = free_cnt; i > pos; i--) begin
        free_start[i] = free_start[i-1];
        free_len[i]   = free_len[i-1];
      end
      free_start[pos] = addr;
      free_len[pos]   = count;
      free_cnt++;
      busy_pages = busy_pages - count;
      push_grant(16'd0, 16'd0, sepa_pkg::StatusOk, 1'b1);
    end
  endfunction

  function automatic void predict_request(request_t r);
    n_requests++;
    case (r.kind)
      sepa_pkg::ReqAlloc: grant_pages(r.count);
      sepa_pkg::ReqFree: return_extent(r.count, r.addr);
      default: begin
        if (r.kind == sepa_pkg::ReqInit) rebuild_free_table();
        push_grant(16'd0, 16'd0, sepa_pkg::StatusOk, 1'b1);
      end
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    request_t r;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      req_type_i     <= ReqNop;
      page_count_i   <= '0;
      page_address_i <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) predict_request('{req_type_i, page_count_i, page_address_i});
      if (pending_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 25)) begin
        r = pending_q.pop_front();
        in_valid_i     <= 1'b1;
        req_type_i     <= r.kind;
        page_count_i   <= r.count;
        page_address_i <= r.addr;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t g;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_cnt    <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (grants_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result start=%0d len=%0d st=%0d",
                                     extent_start_o, extent_length_o, status_o);
        end else begin
          g = grants_q.pop_front();
          if (g !== {extent_start_o, extent_length_o, status_o, pages_in_use_o, last_o})
          begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp s=%0d l=%0d st=%0d use=%0d last=%0d got %0d %0d %0d %0d %0d",
                       g.start, g.length, g.status, g.in_use, g.last, extent_start_o,
                       extent_length_o, status_o, pages_in_use_o, last_o);
          end
        end
      end
      if (hold_cnt > 0) begin
        out_stall_i <= 1'b1;
        hold_cnt    <= hold_cnt - 1;
      end else if (hold_seen != hold_req) begin
        hold_seen   = hold_req;
        out_stall_i <= 1'b1;
        hold_cnt    <= 400;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(0, 99) < 25);
      end
    end
  end

  task automatic add_req(logic [1:0] k, logic [15:0] c, logic [15:0] a);
    pending_q.push_back('{k, c, a});
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sepa_pkg::CfgTotal) cfg_total = val;
    else cfg_reserved = val;
    n_configs++;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || grants_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic add_random(int n);
    int unsigned p;
    repeat (n) begin
      p = $urandom_range(0, 99);
      if (p < 45) begin
        if ($urandom_range(0, 9) == 0) begin
          add_req(sepa_pkg::ReqAlloc, 16'($urandom), 16'($urandom));
        end else begin
          add_req(sepa_pkg::ReqAlloc, 16'($urandom_range(0, 300)), 16'($urandom));
        end
      end else if (p < 82) begin
        if ($urandom_range(0, 9) == 0) begin
          add_req(sepa_pkg::ReqFree, 16'($urandom), 16'($urandom));
        end else begin
          add_req(sepa_pkg::ReqFree, 16'($urandom_range(0, 120)),
                  16'($urandom_range(0, 5000)));
        end
      end else if (p < 92) begin
        add_req(sepa_pkg::ReqInit, 16'($urandom), 16'($urandom));
      end else begin
        add_req(ReqNop, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic run_phase(logic [15:0] tot, logic [15:0] res, int n);
    write_cfg(sepa_pkg::CfgTotal, tot);
    write_cfg(sepa_pkg::CfgReserved, res);
    add_req(sepa_pkg::ReqInit, 16'd0, 16'd0);
    add_random(n);
    drain();
  endtask

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = sepa_pkg::CfgTotal;
    cfg_data_i = '0;
    quiet      = 1'b0;
    hold_req   = 0;
    hold_seen  = 0;
    errors     = 0;
    n_requests = 0;
    n_results  = 0;
    n_configs  = 0;
    cfg_total    = sepa_pkg::ResetTotal;
    cfg_reserved = sepa_pkg::ResetReserved;
    rebuild_free_table();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_req(sepa_pkg::ReqAlloc, 16'd0, 16'hffff);
    add_req(sepa_pkg::ReqAlloc, 16'd1, 16'd0);
    add_req(ReqNop, 16'hffff, 16'hffff);
    add_req(sepa_pkg::ReqFree, 16'd0, 16'd7);
    add_req(sepa_pkg::ReqFree, 16'd3, 16'hfffe);
    add_req(sepa_pkg::ReqFree, 16'd5, 16'd0);
    add_req(sepa_pkg::ReqFree, 16'd2, 16'd2);
    add_req(sepa_pkg::ReqFree, 16'd4, 16'd2);
    add_req(sepa_pkg::ReqAlloc, 16'd2, 16'd0);
    add_req(sepa_pkg::ReqAlloc, 16'd4, 16'd0);
    add_req(sepa_pkg::ReqAlloc, 16'hffff, 16'd0);
    add_req(sepa_pkg::ReqAlloc, 16'd5, 16'd0);
    for (int i = 0; i < 17; i++) add_req(sepa_pkg::ReqFree, 16'd1, 16'(i * 3));
    add_req(sepa_pkg::ReqAlloc, 16'hffff, 16'hffff);
    add_req(sepa_pkg::ReqInit, 16'hffff, 16'hffff);
    drain();

    run_phase(16'd1, 16'd0, 20);
    quiet = 1'b1;
    run_phase(16'hffff, 16'd0, 60);
    quiet = 1'b0;
    hold_req = 1;
    run_phase(16'd4096, 16'd64, 70);
    run_phase(16'd100, 16'd100, 20);
    run_phase(16'hffff, 16'hffff, 20);
    run_phase(16'd16, 16'd15, 30);
    run_phase(16'd600, 16'd10, 110);

    $display("%0d requests over %0d register writes, %0d results checked",
             n_requests, n_configs, n_results);
    $display("covered alloc shortfall, piece cap, table full, wrap, reinit and no-op");
    if (errors == 0) begin
      $display("tb_sorted_extent_page_allocator: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_sorted_extent_page_allocator: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("tb_sorted_extent_page_allocator: errors");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/sepa_pkg.sv
rtl/sepa_ctrl.sv
rtl/sepa_dp.sv
rtl/sorted_extent_page_allocator.sv
sim/tb_sorted_extent_page_allocator.sv
